// ===== src/bpfl_pkg.sv =====
// Package for the buffer pool free list manager.
// Holds field widths, ring sizes, command and status codes and the queue entry type.
// No dependencies.
`default_nettype none

package bpfl_pkg;

  // Id width; the rings hold one entry per buffer id
  localparam int ID_W   = 6;
  localparam int NBUF   = 1 << ID_W;
  localparam int CNT_W  = ID_W + 1;
  localparam int LEN_W  = 20;
  localparam int BIU_W  = 7;
  localparam int PROD_W = 8;
  localparam int CFG_W  = 8;

  // Register reset values
  localparam logic [BIU_W-1:0]  BIU_RESET  = BIU_W'(64);
  localparam logic [PROD_W-1:0] PROD_RESET = PROD_W'(1);

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_COMMIT = 2'd1,
    FUNC_DRAIN  = 2'd2,
    FUNC_DONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RETRY  = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BAD_ID = 2'd3
  } status_t;

  typedef enum logic {
    CFG_BUFS_IN_USE = 1'b0,
    CFG_PRODUCERS   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SIMPLE,
    ST_DRAIN_LEN,
    ST_DRAIN_OUT
  } state_t;

  // One decoded request as it waits in the command queue
  typedef struct packed {
    func_t             func;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/bpfl_front.sv =====
// Front end of the buffer pool manager: accepts request beats, decodes them
// and holds them in a short command queue. Depends on bpfl_pkg.
`default_nettype none

module bpfl_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_func,
  input  wire logic [bpfl_pkg::ID_W-1:0]   in_buf_id,
  input  wire logic [bpfl_pkg::LEN_W-1:0]  in_fill_length,
  output logic                             q_valid,
  output bpfl_pkg::cmd_t                   q_cmd,
  input  wire logic                        q_pop
);

  bpfl_pkg::cmd_t                   q_mem_r [bpfl_pkg::QDEPTH];
  logic [bpfl_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bpfl_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bpfl_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             in_fire;
  bpfl_pkg::cmd_t                   cmd_in;

  function automatic logic [bpfl_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bpfl_pkg::QPTR_W-1:0] p
  );
    logic [bpfl_pkg::QPTR_W-1:0] r;
    if (p == bpfl_pkg::QPTR_W'(bpfl_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + bpfl_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  // Stall while the queue is full
  assign in_stall = (cnt_r == bpfl_pkg::QCNT_W'(bpfl_pkg::QDEPTH));
  assign in_fire  = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // Decode the request beat
  always_comb begin
    cmd_in.func = bpfl_pkg::func_t'(in_func);
    cmd_in.id   = in_buf_id;
    cmd_in.len  = in_fill_length;
  end

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = in_fire ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_fire && !q_pop) begin
      cnt_nxt = cnt_r + bpfl_pkg::QCNT_W'(1);
    end else if (!in_fire && q_pop) begin
      cnt_nxt = cnt_r - bpfl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the decoded beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/bpfl_back.sv =====
// Back end of the buffer pool manager: executes queued commands against the
// free ring, commit ring and length table, and drives the result register.
// Depends on bpfl_pkg.
`default_nettype none

module bpfl_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bpfl_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         q_valid,
  input  wire bpfl_pkg::cmd_t               q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [bpfl_pkg::ID_W-1:0]         out_id,
  output logic [bpfl_pkg::LEN_W-1:0]        out_length,
  output logic                              out_last,
  output logic                              out_all_done
);

  localparam int ID_W  = bpfl_pkg::ID_W;
  localparam int CNT_W = bpfl_pkg::CNT_W;
  localparam int LEN_W = bpfl_pkg::LEN_W;

  typedef struct packed {
    logic pop;
    logic free_rd;
    logic free_wr;
    logic commit_rd;
    logic commit_wr;
    logic len_rd;
    logic emit;
  } ctl_t;

  ctl_t                         ctl;
  bpfl_pkg::state_t             state_r, state_nxt;

  logic [bpfl_pkg::BIU_W-1:0]   biu_r, biu_nxt;
  logic [bpfl_pkg::PROD_W-1:0]  prod_left_r, prod_left_nxt;
  logic [ID_W-1:0]              free_head_r, free_head_nxt;
  logic [CNT_W-1:0]             free_cnt_r, free_cnt_nxt;
  logic [ID_W-1:0]              commit_head_r, commit_head_nxt;
  logic [CNT_W-1:0]             commit_cnt_r, commit_cnt_nxt;
  logic [bpfl_pkg::NBUF-1:0]    free_wr_r, free_wr_nxt;
  bpfl_pkg::status_t            res_status_r, res_status_nxt;

  // Ring and table storage
  logic [ID_W-1:0]              free_mem   [bpfl_pkg::NBUF];
  logic [ID_W-1:0]              commit_mem [bpfl_pkg::NBUF];
  logic [LEN_W-1:0]             len_mem    [bpfl_pkg::NBUF];

  logic [ID_W-1:0]              free_rd_r;
  logic                         free_rd_wr_r;
  logic [ID_W-1:0]              free_rd_idx_r;
  logic [ID_W-1:0]              commit_rd_r;
  logic [LEN_W-1:0]             len_rd_r;

  logic                         out_valid_r;
  bpfl_pkg::status_t            out_status_r;
  logic [ID_W-1:0]              out_id_r;
  logic [LEN_W-1:0]             out_length_r;
  logic                         out_last_r;
  logic                         out_all_done_r;

  logic                         out_free;
  logic [CNT_W-1:0]             limit;
  logic                         commit_ok;
  logic [ID_W-1:0]              free_tail;
  logic [ID_W-1:0]              commit_tail;
  logic [ID_W-1:0]              alloc_id;
  logic                         all_done;

  // Ring position base + off, folded once into the ring
  function automatic logic [ID_W-1:0] ring_pos(
    input logic [ID_W-1:0]  base,
    input logic [CNT_W-1:0] off
  );
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(bpfl_pkg::NBUF)) begin
      sum = sum - (CNT_W+1)'(bpfl_pkg::NBUF);
    end
    return sum[ID_W-1:0];
  endfunction

  // Clamp the pool size to the ring depth
  function automatic logic [CNT_W-1:0] pool_limit(
    input logic [bpfl_pkg::BIU_W-1:0] biu
  );
    logic [CNT_W-1:0] r;
    if (CNT_W'(biu) > CNT_W'(bpfl_pkg::NBUF)) begin
      r = CNT_W'(bpfl_pkg::NBUF);
    end else begin
      r = CNT_W'(biu);
    end
    return r;
  endfunction

  assign out_free    = !out_valid_r || !out_stall;
  assign limit       = pool_limit(biu_r);
  assign commit_ok   = (CNT_W'(q_cmd.id) < limit) &&
                       (commit_cnt_r != CNT_W'(bpfl_pkg::NBUF));
  assign free_tail   = ring_pos(free_head_r, free_cnt_r);
  assign commit_tail = ring_pos(commit_head_r, commit_cnt_r);
  // An untouched free-ring slot still holds its own index
  assign alloc_id    = free_rd_wr_r ? free_rd_r : free_rd_idx_r;
  assign all_done    = (prod_left_r == '0) && (commit_cnt_r == '0);
  assign q_pop       = ctl.pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpfl_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.func)
            bpfl_pkg::FUNC_ALLOC: begin
              state_nxt = (free_cnt_r != '0) ? bpfl_pkg::ST_ALLOC : bpfl_pkg::ST_SIMPLE;
            end
            bpfl_pkg::FUNC_DRAIN: begin
              state_nxt = (commit_cnt_r != '0) ? bpfl_pkg::ST_DRAIN_LEN
                                                : bpfl_pkg::ST_SIMPLE;
            end
            default: begin
              state_nxt = bpfl_pkg::ST_SIMPLE;
            end
          endcase
        end
      end
      bpfl_pkg::ST_ALLOC, bpfl_pkg::ST_SIMPLE: begin
        if (out_free) begin
          state_nxt = bpfl_pkg::ST_IDLE;
        end
      end
      bpfl_pkg::ST_DRAIN_LEN: begin
        state_nxt = bpfl_pkg::ST_DRAIN_OUT;
      end
      bpfl_pkg::ST_DRAIN_OUT: begin
        if (out_free) begin
          state_nxt = (commit_cnt_r != '0) ? bpfl_pkg::ST_DRAIN_LEN : bpfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpfl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      bpfl_pkg::ST_IDLE: begin
        if (q_valid) begin
          ctl.pop = 1'b1;
          case (q_cmd.func)
            bpfl_pkg::FUNC_ALLOC:  ctl.free_rd   = (free_cnt_r != '0);
            bpfl_pkg::FUNC_COMMIT: ctl.commit_wr = commit_ok;
            bpfl_pkg::FUNC_DRAIN:  ctl.commit_rd = (commit_cnt_r != '0);
            default:               ctl.pop       = 1'b1;
          endcase
        end
      end
      bpfl_pkg::ST_ALLOC, bpfl_pkg::ST_SIMPLE: begin
        ctl.emit = out_free;
      end
      bpfl_pkg::ST_DRAIN_LEN: begin
        ctl.len_rd  = 1'b1;
        ctl.free_wr = (free_cnt_r < CNT_W'(bpfl_pkg::NBUF));
      end
      bpfl_pkg::ST_DRAIN_OUT: begin
        ctl.emit      = out_free;
        ctl.commit_rd = out_free && (commit_cnt_r != '0);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Ring pointers, counts and configuration
  always_comb begin
    biu_nxt         = biu_r;
    prod_left_nxt   = prod_left_r;
    free_head_nxt   = free_head_r;
    free_cnt_nxt    = free_cnt_r;
    commit_head_nxt = commit_head_r;
    commit_cnt_nxt  = commit_cnt_r;
    free_wr_nxt     = free_wr_r;
    res_status_nxt  = res_status_r;
    if (cfg_we) begin
      case (bpfl_pkg::cfg_idx_t'(cfg_index))
        bpfl_pkg::CFG_BUFS_IN_USE: begin
          // Reload the pool and empty the commit ring
          biu_nxt         = cfg_wdata[bpfl_pkg::BIU_W-1:0];
          free_head_nxt   = '0;
          free_cnt_nxt    = pool_limit(cfg_wdata[bpfl_pkg::BIU_W-1:0]);
          commit_head_nxt = '0;
          commit_cnt_nxt  = '0;
          free_wr_nxt     = '0;
        end
        bpfl_pkg::CFG_PRODUCERS: begin
          prod_left_nxt = cfg_wdata[bpfl_pkg::PROD_W-1:0];
        end
        default: begin
          biu_nxt = biu_r;
        end
      endcase
    end else begin
      if (ctl.pop) begin
        case (q_cmd.func)
          bpfl_pkg::FUNC_ALLOC: begin
            res_status_nxt = bpfl_pkg::STAT_RETRY;
          end
          bpfl_pkg::FUNC_COMMIT: begin
            res_status_nxt = commit_ok ? bpfl_pkg::STAT_OK : bpfl_pkg::STAT_BAD_ID;
          end
          bpfl_pkg::FUNC_DRAIN: begin
            res_status_nxt = bpfl_pkg::STAT_EMPTY;
          end
          default: begin
            res_status_nxt = bpfl_pkg::STAT_OK;
            if (prod_left_r != '0) begin
              prod_left_nxt = prod_left_r - bpfl_pkg::PROD_W'(1);
            end
          end
        endcase
      end
      if (ctl.free_rd) begin
        free_head_nxt = ring_pos(free_head_r, CNT_W'(1));
        free_cnt_nxt  = free_cnt_r - CNT_W'(1);
      end
      if (ctl.commit_wr) begin
        commit_cnt_nxt = commit_cnt_r + CNT_W'(1);
      end
      if (ctl.len_rd) begin
        commit_head_nxt = ring_pos(commit_head_r, CNT_W'(1));
        commit_cnt_nxt  = commit_cnt_r - CNT_W'(1);
      end
      if (ctl.free_wr) begin
        free_cnt_nxt           = free_cnt_r + CNT_W'(1);
        free_wr_nxt[free_tail] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bpfl_pkg::ST_IDLE;
      biu_r         <= bpfl_pkg::BIU_RESET;
      prod_left_r   <= bpfl_pkg::PROD_RESET;
      free_head_r   <= '0;
      free_cnt_r    <= pool_limit(bpfl_pkg::BIU_RESET);
      commit_head_r <= '0;
      commit_cnt_r  <= '0;
      free_wr_r     <= '0;
      res_status_r  <= bpfl_pkg::STAT_OK;
    end else begin
      state_r       <= state_nxt;
      biu_r         <= biu_nxt;
      prod_left_r   <= prod_left_nxt;
      free_head_r   <= free_head_nxt;
      free_cnt_r    <= free_cnt_nxt;
      commit_head_r <= commit_head_nxt;
      commit_cnt_r  <= commit_cnt_nxt;
      free_wr_r     <= free_wr_nxt;
      res_status_r  <= res_status_nxt;
    end
  end

  // Free ring: push drained ids, pop at head
  always_ff @(posedge clk) begin
    if (ctl.free_wr) begin
      free_mem[free_tail] <= commit_rd_r;
    end
    if (ctl.free_rd) begin
      free_rd_r     <= free_mem[free_head_r];
      free_rd_wr_r  <= free_wr_r[free_head_r];
      free_rd_idx_r <= free_head_r;
    end
  end

  // Commit ring: append committed ids, read the oldest
  always_ff @(posedge clk) begin
    if (ctl.commit_wr) begin
      commit_mem[commit_tail] <= q_cmd.id;
    end
    if (ctl.commit_rd) begin
      commit_rd_r <= commit_mem[commit_head_r];
    end
  end

  // Length table: newest length per id
  always_ff @(posedge clk) begin
    if (ctl.commit_wr) begin
      len_mem[q_cmd.id] <= q_cmd.len;
    end
    if (ctl.len_rd) begin
      len_rd_r <= len_mem[commit_rd_r];
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_all_done_r <= all_done;
      case (state_r)
        bpfl_pkg::ST_ALLOC: begin
          out_status_r <= bpfl_pkg::STAT_OK;
          out_id_r     <= alloc_id;
          out_length_r <= '0;
          out_last_r   <= 1'b1;
        end
        bpfl_pkg::ST_DRAIN_OUT: begin
          out_status_r <= bpfl_pkg::STAT_OK;
          out_id_r     <= commit_rd_r;
          out_length_r <= len_rd_r;
          out_last_r   <= (commit_cnt_r == '0);
        end
        default: begin
          out_status_r <= res_status_r;
          out_id_r     <= '0;
          out_length_r <= '0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_id       = out_id_r;
  assign out_length   = out_length_r;
  assign out_last     = out_last_r;
  assign out_all_done = out_all_done_r;

`ifndef SYNTHESIS
  a_free_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(bpfl_pkg::NBUF))
    else $error("free ring count beyond depth");

  a_commit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    commit_cnt_r <= CNT_W'(bpfl_pkg::NBUF))
    else $error("commit ring count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.free_rd |-> (free_cnt_r != '0) && (state_nxt == bpfl_pkg::ST_ALLOC))
    else $error("free ring popped while empty");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpfl_pkg::ST_DRAIN_OUT && ctl.emit && commit_cnt_r == '0)
    |=> (state_r == bpfl_pkg::ST_IDLE) && out_valid_r && out_last_r)
    else $error("drain did not close with a last beat");
`endif

endmodule

`default_nettype wire

// ===== src/buffer_pool_free_list_manager.sv =====
// Buffer pool free list manager: top level joining the command front end
// and the ring execution back end. Depends on bpfl_pkg, bpfl_front, bpfl_back.
//
// Usage: requests arrive on the in_ channel (valid/stall), one beat per
// allocate, commit, drain or producer-done request; results leave on the
// out_ channel, one beat per result, with out_last on the final beat of each
// request. A drain returns one beat per committed buffer, oldest first.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
// writing the pool size reloads the free ring and empties the commit ring.
// A request beat passes through the command queue, the back-end state register
// and the output register before its result appears. The back end takes a
// new command only in its idle state, so it finishes each request before it
// takes the next; a drain reads the commit ring and then the dependent length
// table for each entry. A two-entry command queue lets the input side keep
// taking beats while the back end works or the output stalls.
// Reset (synchronous, rst_n low): pool of 64 ids, one producer, empty commit
// ring. A stalled result holds in the output register; the back end waits,
// and once the queue fills in_stall rises.
`default_nettype none

module buffer_pool_free_list_manager (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bpfl_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [bpfl_pkg::ID_W-1:0]    in_buf_id,
  input  wire logic [bpfl_pkg::LEN_W-1:0]   in_fill_length,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [bpfl_pkg::ID_W-1:0]         out_id,
  output logic [bpfl_pkg::LEN_W-1:0]        out_length,
  output logic                              out_last,
  output logic                              out_all_done
);

  logic            q_valid;
  logic            q_pop;
  bpfl_pkg::cmd_t  q_cmd;

  // Accept and queue request beats
  bpfl_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_buf_id      (in_buf_id),
    .in_fill_length (in_fill_length),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  // Execute commands and drive results
  bpfl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_id       (out_id),
    .out_length   (out_length),
    .out_last     (out_last),
    .out_all_done (out_all_done)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for buffer_pool_free_list_manager.
// Drives requests and register writes, predicts every result beat in a local
// pool model and compares in order. Depends on bpfl_pkg and the RTL top.
`default_nettype none

module tb;

  localparam int ID_W   = bpfl_pkg::ID_W;
  localparam int LEN_W  = bpfl_pkg::LEN_W;
  localparam int CFG_W  = bpfl_pkg::CFG_W;
  localparam int CNT_W  = bpfl_pkg::CNT_W;
  localparam int BIU_W  = bpfl_pkg::BIU_W;
  localparam int PROD_W = bpfl_pkg::PROD_W;
  localparam int NBUF   = bpfl_pkg::NBUF;

  localparam int SETTLE     = 8;     // quiet cycles before a register write
  localparam int STUCK_MAX  = 2000;  // cycles with no beat on either side
  localparam int RAND_ITEMS = 400;

  // One expected or observed result beat
  typedef struct packed {
    bpfl_pkg::status_t status;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              all_done;
  } result_t;

  // One row of the directed plan: a register write pair or a request
  typedef struct packed {
    bit                cfg;
    logic [CFG_W-1:0]  biu;
    logic [CFG_W-1:0]  prod;
    bpfl_pkg::func_t   func;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    bit                typed;
    result_t           want;
  } plan_row_t;

  localparam result_t NO_RESULT  = '0;
  localparam result_t OK_BUSY    = '{bpfl_pkg::STAT_OK, '0, '0, 1'b1, 1'b0};
  localparam result_t OK_IDLE    = '{bpfl_pkg::STAT_OK, '0, '0, 1'b1, 1'b1};
  localparam result_t EMPTY_BUSY = '{bpfl_pkg::STAT_EMPTY, '0, '0, 1'b1, 1'b0};
  localparam result_t RETRY_IDLE = '{bpfl_pkg::STAT_RETRY, '0, '0, 1'b1, 1'b1};
  localparam result_t RETRY_BUSY = '{bpfl_pkg::STAT_RETRY, '0, '0, 1'b1, 1'b0};
  localparam result_t BAD_IDLE   = '{bpfl_pkg::STAT_BAD_ID, '0, '0, 1'b1, 1'b1};
  localparam result_t BAD_BUSY   = '{bpfl_pkg::STAT_BAD_ID, '0, '0, 1'b1, 1'b0};

  localparam int NPLAN = 26;
  localparam plan_row_t PLAN [NPLAN] = '{
    // reset pool: 64 ids, one producer
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DRAIN,  6'd0,  20'h00000, 1'b1, EMPTY_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b1,
      '{bpfl_pkg::STAT_OK, 6'd0, 20'd0, 1'b1, 1'b0}},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b1,
      '{bpfl_pkg::STAT_OK, 6'd1, 20'd0, 1'b1, 1'b0}},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd63, 20'hFFFFF, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd0,  20'h00000, 1'b1, OK_BUSY},
    // same id queued twice, newest length wins
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd63, 20'h00005, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DRAIN,  6'd0,  20'h00000, 1'b0, NO_RESULT},
    // producer count runs out, then saturates
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DONE,   6'd0,  20'h00000, 1'b1, OK_IDLE},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DONE,   6'd0,  20'h00000, 1'b1, OK_IDLE},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd42, 20'hAAAAA, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd21, 20'h55555, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DRAIN,  6'd0,  20'h00000, 1'b0, NO_RESULT},
    // single-buffer pool, no producers
    '{1'b1, 8'd1, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b1,
      '{bpfl_pkg::STAT_OK, 6'd0, 20'd0, 1'b1, 1'b1}},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b1, RETRY_IDLE},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd1,  20'h00007, 1'b1, BAD_IDLE},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd0,  20'h00009, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DRAIN,  6'd0,  20'h00000, 1'b0, NO_RESULT},
    // empty pool, most producers
    '{1'b1, 8'd0, 8'd255, bpfl_pkg::FUNC_ALLOC, 6'd0, 20'h00000, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b1, RETRY_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd0,  20'h00001, 1'b1, BAD_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DONE,   6'd0,  20'h00000, 1'b1, OK_BUSY},
    // oversized pool write clamps to the ring size
    '{1'b1, 8'd200, 8'd2, bpfl_pkg::FUNC_ALLOC, 6'd0, 20'h00000, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_COMMIT, 6'd63, 20'h00003, 1'b1, OK_BUSY},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_ALLOC,  6'd0,  20'h00000, 1'b0, NO_RESULT},
    '{1'b0, 8'd0, 8'd0, bpfl_pkg::FUNC_DRAIN,  6'd0,  20'h00000, 1'b0, NO_RESULT}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_func;
  logic [ID_W-1:0]    in_buf_id;
  logic [LEN_W-1:0]   in_fill_length;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [ID_W-1:0]    out_id;
  logic [LEN_W-1:0]   out_length;
  logic               out_last;
  logic               out_all_done;

  buffer_pool_free_list_manager dut (.*);

  // Local pool model
  logic [ID_W-1:0]   m_free [NBUF];
  logic [ID_W-1:0]   m_free_head;
  logic [CNT_W-1:0]  m_free_cnt;
  logic [ID_W-1:0]   m_commit [NBUF];
  logic [ID_W-1:0]   m_commit_head;
  logic [CNT_W-1:0]  m_commit_cnt;
  logic [LEN_W-1:0]  m_len [NBUF];
  logic [BIU_W-1:0]  m_biu;
  logic [PROD_W-1:0] m_prod_left;

  result_t step_results[$];   // beats caused by the latest request
  result_t due_results[$];    // beats still owed by the block
  result_t head_result;
  logic [ID_W-1:0] held_ids[$];  // ids allocated and not yet committed

  int  errors;
  int  sent_items;
  int  stuck_cycles;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Refill the free ring and empty the commit queue
  function automatic void pool_reload();
    int n;
    n = (int'(m_biu) > NBUF) ? NBUF : int'(m_biu);
    for (int i = 0; i < NBUF; i++) m_free[i] = ID_W'(i);
    m_free_head   = '0;
    m_free_cnt    = CNT_W'(n);
    m_commit_head = '0;
    m_commit_cnt  = '0;
  endfunction

  function automatic void pool_note(bpfl_pkg::status_t s, logic [ID_W-1:0] id,
                                    logic [LEN_W-1:0] len, logic last);
    result_t r;
    r.status   = s;
    r.id       = id;
    r.len      = len;
    r.last     = last;
    r.all_done = (m_prod_left == 0) && (m_commit_cnt == 0);
    step_results.push_back(r);
  endfunction

  // Apply one request to the pool model and collect the beats it causes
  function automatic void pool_predict(bpfl_pkg::func_t f, logic [ID_W-1:0] id,
                                       logic [LEN_W-1:0] len);
    int limit;
    int k;
    logic [ID_W-1:0]  d;
    logic [LEN_W-1:0] dl;
    limit = (int'(m_biu) > NBUF) ? NBUF : int'(m_biu);
    step_results.delete();
    case (f)
      bpfl_pkg::FUNC_ALLOC: begin
        if (m_free_cnt == 0) begin
          pool_note(bpfl_pkg::STAT_RETRY, '0, '0, 1'b1);
        end else begin
          d = m_free[m_free_head];
          m_free_head++;
          m_free_cnt--;
          pool_note(bpfl_pkg::STAT_OK, d, '0, 1'b1);
        end
      end
      bpfl_pkg::FUNC_COMMIT: begin
        if (int'(id) >= limit || int'(m_commit_cnt) >= NBUF) begin
          pool_note(bpfl_pkg::STAT_BAD_ID, '0, '0, 1'b1);
        end else begin
          m_commit[ID_W'(m_commit_head + m_commit_cnt)] = id;
          m_len[id] = len;
          m_commit_cnt++;
          pool_note(bpfl_pkg::STAT_OK, '0, '0, 1'b1);
        end
      end
      bpfl_pkg::FUNC_DRAIN: begin
        if (m_commit_cnt == 0) begin
          pool_note(bpfl_pkg::STAT_EMPTY, '0, '0, 1'b1);
        end else begin
          k = 0;
          while (m_commit_cnt > 0 && k < NBUF) begin
            d  = m_commit[m_commit_head];
            dl = m_len[d];
            m_commit_head++;
            m_commit_cnt--;
            // drop the id when the free ring is already full
            if (int'(m_free_cnt) < NBUF) begin
              m_free[ID_W'(m_free_head + m_free_cnt)] = d;
              m_free_cnt++;
            end
            pool_note(bpfl_pkg::STAT_OK, d, dl, (m_commit_cnt == 0) || (k + 1 == NBUF));
            k++;
          end
        end
      end
      default: begin
        if (m_prod_left > 0) m_prod_left--;
        pool_note(bpfl_pkg::STAT_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Mostly short gaps, a few long ones, none in a calm stretch
  function automatic int pace_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] fill_len_pick();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEN_W'($urandom);
    endcase
  endfunction

  // Predict, then present one request beat and hold it until taken
  task automatic issue_request(bpfl_pkg::func_t f, logic [ID_W-1:0] id,
                               logic [LEN_W-1:0] len,
                               bit typed = 1'b0, result_t want = '0);
    int gap;
    pool_predict(f, id, len);
    if (f == bpfl_pkg::FUNC_ALLOC && step_results[0].status == bpfl_pkg::STAT_OK)
      held_ids.push_back(step_results[0].id);
    if (typed) due_results.push_back(want);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    gap = pace_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_buf_id      <= id;
    in_fill_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  // Wait for the block to go quiet, then write both registers
  task automatic reconfigure(logic [CFG_W-1:0] biu, logic [CFG_W-1:0] prod);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bpfl_pkg::CFG_BUFS_IN_USE;
    cfg_wdata <= biu;
    @(posedge clk);
    cfg_index <= bpfl_pkg::CFG_PRODUCERS;
    cfg_wdata <= prod;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_biu       = biu[BIU_W-1:0];
    m_prod_left = prod;
    pool_reload();
    held_ids.delete();
  endtask

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  // Compare each taken result beat with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got status %0h id %0h length %0h",
                 $time, out_status, out_id, out_length);
        errors++;
      end else begin
        head_result = due_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(out_status));
        check_field("id", 32'(head_result.id), 32'(out_id));
        check_field("length", 32'(head_result.len), 32'(out_length));
        check_field("last", 32'(head_result.last), 32'(out_last));
        check_field("all_done", 32'(head_result.all_done), 32'(out_all_done));
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_MAX) begin
        $display("%0t: watchdog: no beat for %0d cycles", $time, STUCK_MAX);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side back-pressure: open runs broken by stalls
  initial begin : result_pacer
    int n;
    forever begin
      out_stall <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
      n = pace_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int k;
    int j;
    int rand_base;
    logic [CFG_W-1:0] biu;
    logic [CFG_W-1:0] prod;
    logic [ID_W-1:0]  id;
    errors         = 0;
    sent_items     = 0;
    stuck_cycles   = 0;
    calm           = 1'b0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= bpfl_pkg::CFG_BUFS_IN_USE;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_func        <= bpfl_pkg::FUNC_ALLOC;
    in_buf_id      <= '0;
    in_fill_length <= '0;
    m_biu       = bpfl_pkg::BIU_RESET;
    m_prod_left = bpfl_pkg::PROD_RESET;
    pool_reload();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan
    foreach (PLAN[i]) begin
      if (PLAN[i].cfg) reconfigure(PLAN[i].biu, PLAN[i].prod);
      else issue_request(PLAN[i].func, PLAN[i].id, PLAN[i].len, PLAN[i].typed,
                         PLAN[i].want);
    end

    // Fill the commit queue to the brim, overflow it, drain it in one go
    reconfigure(8'd64, 8'd1);
    repeat (NBUF) issue_request(bpfl_pkg::FUNC_COMMIT, ID_W'($urandom), fill_len_pick());
    issue_request(bpfl_pkg::FUNC_COMMIT, 6'd5, 20'd1, 1'b1, BAD_BUSY);
    issue_request(bpfl_pkg::FUNC_ALLOC, '0, '0);
    issue_request(bpfl_pkg::FUNC_DRAIN, '0, '0);
    issue_request(bpfl_pkg::FUNC_DRAIN, '0, '0, 1'b1, EMPTY_BUSY);

    // Random part: mostly allocate/commit/drain rounds on held ids
    rand_base = sent_items;
    while (sent_items < rand_base + RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 7))
          0:       biu = 8'd1;
          1:       biu = 8'd64;
          2:       biu = 8'd0;
          3:       biu = 8'd127;
          4:       biu = CFG_W'($urandom_range(128, 255));
          default: biu = CFG_W'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 5))
          0:       prod = 8'd0;
          1:       prod = 8'd255;
          default: prod = CFG_W'($urandom_range(0, 4));
        endcase
        reconfigure(biu, prod);
      end
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(1, 8);
          repeat (k)
            issue_request(bpfl_pkg::FUNC_ALLOC, ID_W'($urandom), LEN_W'($urandom));
          while (held_ids.size() > 0 && $urandom_range(0, 7) != 0) begin
            j  = $urandom_range(0, held_ids.size() - 1);
            id = held_ids[j];
            held_ids.delete(j);
            issue_request(bpfl_pkg::FUNC_COMMIT, id, fill_len_pick());
          end
          if ($urandom_range(0, 3) == 0) issue_request(bpfl_pkg::FUNC_DONE, '0, '0);
          if ($urandom_range(0, 2) != 0) issue_request(bpfl_pkg::FUNC_DRAIN, '0, '0);
        end
        6, 7: begin
          k = $urandom_range(1, 10);
          repeat (k)
            issue_request(bpfl_pkg::func_t'($urandom_range(0, 3)), ID_W'($urandom),
                          LEN_W'($urandom));
        end
        8: begin
          k = $urandom_range(1, 3);
          repeat (k)
            issue_request(bpfl_pkg::FUNC_DONE, ID_W'($urandom), LEN_W'($urandom));
        end
        default: issue_request(bpfl_pkg::FUNC_DRAIN, ID_W'($urandom), LEN_W'($urandom));
      endcase
    end

    // Wait out every owed beat, then a few more cycles for strays
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/bpfl_pkg.sv
src/bpfl_front.sv
src/bpfl_back.sv
src/buffer_pool_free_list_manager.sv
verif/tb.sv
